/* src/phpc_pkg.sv */
// Package with constants and the modular adder for the packet header and payload checksum.
package phpc_pkg;

   localparam logic [22:0] MODULUS = 23'h7FFFFF;

   localparam logic [3:0] POS_SRC_ADDR = 4'd3;
   localparam logic [3:0] POS_DST_ADDR = 4'd6;
   localparam logic [3:0] POS_PORTS    = 4'd7;
   localparam logic [3:0] POS_FRAG     = 4'd9;
   localparam logic [3:0] POS_LENGTH   = 4'd11;
   localparam logic [3:0] POS_HOP      = 4'd12;
   localparam logic [3:0] POS_CLASS    = 4'd15;

   localparam logic [7:0] HI_NIBBLE = 8'hF0;
   localparam logic [7:0] LO_NIBBLE = 8'h0F;

   localparam int CHECKSUM_W = 23;
   localparam int LENGTH_W   = 14;
   localparam int RSP_W      = 40;

   typedef logic [CHECKSUM_W-1:0] checksum_type;
   typedef logic [LENGTH_W-1:0]   length_type;

   function automatic checksum_type mod_add(checksum_type acc, logic [31:0] v);
      logic [24:0] s;
      logic [23:0] f;
      s = {2'b00, acc} + {2'b00, v[22:0]} + {16'd0, v[31:23]};
      f = {1'b0, s[22:0]} + {22'd0, s[24:23]};
      if (f >= {1'b0, MODULUS}) begin
         f = f - {1'b0, MODULUS};
      end
      return f[22:0];
   endfunction

endpackage

/* src/packet_header_payload_checksum.sv */
// Packet header and payload checksum: top level.
// Takes one packet byte per request, one request per cycle sustained, with no gaps between
// packets. Header bytes 0 to 15 carry address, port, offset, length, hop and class
// fields; payload words follow big-endian while their start is below the length.
// Each byte passes an input register, one modular add into its running sum and a second one
// that combines the two sums; at the last byte of a packet the combined sum is written to
// the result register, which is held back while an earlier result still waits.
// The result carries the checksum modulo 2^23-1 and the length field; the input keeps
// flowing while a result waits, and stalls only if a second result would overwrite it.
module packet_header_payload_checksum (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // [22:0] checksum_value, [36:23] length_field, zero fill
);
   import phpc_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic [14:0]  pos_ff, pos_in;
   logic [23:0]  shift_ff;
   checksum_type field_sum_ff, field_sum_in;
   checksum_type payload_sum_ff, payload_sum_in;
   length_type   length_ff, length_in;
   logic         rsp_valid_ff, rsp_valid_in;
   checksum_type rsp_sum_ff, rsp_sum_in;
   length_type   rsp_len_ff, rsp_len_in;

   logic [31:0]  cur;
   logic [31:0]  addend;
   logic [31:0]  mag;
   logic         in_header;
   logic         word_end;
   logic         fin;
   logic         advance;
   logic [15:0]  pos_next_wide;

   assign cur           = {shift_ff, in_byte_ff};
   assign in_header     = (pos_ff[14:4] == 11'd0);
   assign word_end      = !in_header && (pos_ff[1:0] == 2'b11);
   assign pos_next_wide = {1'b0, pos_ff} + 16'd1;
   assign mag           = cur[31] ? (~cur + 32'd1) : cur;

   always_comb begin
      addend    = 32'd0;
      length_in = length_ff;
      if (in_header) begin
         unique case (pos_ff[3:0])
            POS_SRC_ADDR: addend = {4'd0, cur[31:4]};
            POS_DST_ADDR: addend = {4'd0, cur[27:0]};
            POS_PORTS:    addend = {23'd0, {1'b0, (in_byte_ff & HI_NIBBLE) >> 4}
                                         + {1'b0, in_byte_ff & LO_NIBBLE}};
            POS_FRAG:     addend = {18'd0, cur[15:2]};
            POS_LENGTH: begin
               addend    = {18'd0, cur[17:4]};
               length_in = cur[17:4];
            end
            POS_HOP:      addend = {27'd0, cur[11:8], in_byte_ff[7]};
            POS_CLASS:    addend = {25'd0, {5'd0, in_byte_ff[7:6]} + {1'b0, in_byte_ff[5:0]}};
            default:      addend = 32'd0;
         endcase
      end
   end

   always_comb begin
      field_sum_in   = field_sum_ff;
      payload_sum_in = payload_sum_ff;
      fin            = 1'b0;
      if (in_header) begin
         field_sum_in = mod_add(field_sum_ff, addend);
         fin = (pos_ff[3:0] == POS_CLASS) && (length_ff <= 14'd16);
      end else if (word_end) begin
         payload_sum_in = mod_add(payload_sum_ff, mag);
         fin = (pos_next_wide >= {2'b00, length_ff});
      end
      rsp_sum_in = mod_add(field_sum_in, {9'd0, payload_sum_in});
      rsp_len_in = length_in;
   end

   assign advance     = in_valid_ff && (!fin || !rsp_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_comb begin
      pos_in = pos_ff;
      if (advance) begin
         pos_in = fin ? 15'd0 : pos_next_wide[14:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance && fin) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         pos_ff         <= '0;
         field_sum_ff   <= '0;
         payload_sum_ff <= '0;
         length_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            if (fin) begin
               field_sum_ff   <= '0;
               payload_sum_ff <= '0;
               length_ff      <= '0;
            end else begin
               field_sum_ff   <= field_sum_in;
               payload_sum_ff <= payload_sum_in;
               length_ff      <= length_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata;
      end
      if (advance) begin
         shift_ff <= cur[23:0];
      end
      if (advance && fin) begin
         rsp_sum_ff <= rsp_sum_in;
         rsp_len_ff <= rsp_len_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rsp_len_ff, rsp_sum_ff};

`ifndef SYNTH
   a_fin_position: assert property (@(posedge clock) disable iff (reset)
      (advance && fin) |-> ((pos_ff == 15'd15) || word_end))
      else $error("packet end at a byte that cannot close a packet");

   a_pos_restart: assert property (@(posedge clock) disable iff (reset)
      (advance && fin) |=> (pos_ff == 15'd0))
      else $error("byte position not cleared after packet end");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !(advance && fin))
      else $error("pending result overwritten");

   a_sum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_sum_ff < MODULUS))
      else $error("checksum not reduced");
`endif

endmodule

/* verif/tb_top.sv */
// Testbench for the packet header and payload checksum block: directed and random packets.
`timescale 1ns / 100ps

module tb_top;
   import phpc_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 1000000;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned RANDOM_BYTES = 1000;
   localparam int unsigned RANDOM_PKTS  = 12;

   typedef struct packed {
      checksum_type checksum;
      length_type   length;
   } checksum_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;    // [7:0] data_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [22:0] checksum_value, [36:23] length_field, zero fill

   checksum_result_type checksum_queue[$];
   logic [31:0]         word_fill[$];

   // Tracked packet state, one byte at a time.
   logic [14:0]  pkt_pos;
   logic [31:0]  hdr_shift;
   checksum_type field_acc;
   checksum_type payload_acc;
   logic [31:0]  word_acc;
   length_type   pkt_length;

   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned bytes_sent = 0;
   int unsigned burst_left = 0;
   int unsigned hold_left = 0;

   packet_header_payload_checksum dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   function automatic checksum_type add_mod23(checksum_type acc, longint unsigned v);
      return checksum_type'((longint'(acc) + v) % longint'(MODULUS));
   endfunction

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'hFFFF_FFFF;
         3: return 32'h0000_0000;
         4: return 32'h8000_0001;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [127:0] random_header();
      return {$urandom(), $urandom(), $urandom(), $urandom()};
   endfunction

   task automatic clear_packet_state();
      pkt_pos     = '0;
      hdr_shift   = '0;
      field_acc   = '0;
      payload_acc = '0;
      word_acc    = '0;
      pkt_length  = '0;
   endtask

   task automatic close_packet();
      checksum_result_type r;
      r.checksum = add_mod23(field_acc, payload_acc);
      r.length   = pkt_length;
      checksum_queue.push_back(r);
      clear_packet_state();
   endtask

   task automatic checksum_track_byte(input logic [7:0] b);
      logic [31:0] mag;
      hdr_shift = {hdr_shift[23:0], b};
      if (pkt_pos < 15'd16) begin
         case (pkt_pos[3:0])
            POS_SRC_ADDR: field_acc = add_mod23(field_acc, hdr_shift >> 4);
            POS_DST_ADDR: field_acc = add_mod23(field_acc, hdr_shift[27:0]);
            POS_PORTS:    field_acc = add_mod23(field_acc, b[7:4] + b[3:0]);
            POS_FRAG:     field_acc = add_mod23(field_acc, hdr_shift[15:2]);
            POS_LENGTH: begin
               pkt_length = hdr_shift[17:4];
               field_acc  = add_mod23(field_acc, pkt_length);
            end
            POS_HOP:      field_acc = add_mod23(field_acc, {hdr_shift[11:8], b[7]});
            POS_CLASS: begin
               field_acc = add_mod23(field_acc, b[7:6] + b[5:0]);
               if (pkt_length <= 14'd16) begin
                  close_packet();
                  return;
               end
            end
            default: ;
         endcase
         pkt_pos = pkt_pos + 15'd1;
         return;
      end
      word_acc = {word_acc[23:0], b};
      if (pkt_pos[1:0] == 2'd3) begin
         mag = word_acc[31] ? (~word_acc + 32'd1) : word_acc;
         payload_acc = add_mod23(payload_acc, mag);
         word_acc = '0;
         if (32'(pkt_pos) + 32'd1 >= 32'(pkt_length)) begin
            close_packet();
            return;
         end
      end
      pkt_pos = pkt_pos + 15'd1;
   endtask

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      bytes_sent++;
      checksum_track_byte(b);
   endtask

   task automatic send_packet(input logic [127:0] hdr_bytes, input length_type len);
      logic [31:0] w;
      int n_words;
      hdr_bytes[9*8 +: 2]    = len[13:12];
      hdr_bytes[10*8 +: 8]   = len[11:4];
      hdr_bytes[11*8+4 +: 4] = len[3:0];
      for (int i = 0; i < 16; i++) begin
         send_byte(hdr_bytes[i*8 +: 8]);
      end
      n_words = (len <= 14'd16) ? 0 : (int'(len) - 16 + 3) / 4;
      for (int k = 0; k < n_words; k++) begin
         w = (word_fill.size() != 0) ? word_fill.pop_front() : random_word();
         for (int j = 3; j >= 0; j--) begin
            send_byte(w[j*8 +: 8]);
         end
      end
   endtask

   task automatic test_short_length();
      send_packet(128'd0, 14'd0);
      send_packet({16{8'hFF}}, 14'd16);
      send_packet({16{8'hFF}}, 14'd1);
      send_packet(random_header(), 14'd9);
   endtask

   task automatic test_partial_word();
      word_fill.push_back(32'h7FFF_FFFF);
      send_packet(random_header(), 14'd17);
      word_fill.push_back(32'h8000_0000);
      send_packet(random_header(), 14'd19);
      send_packet(random_header(), 14'd20);
      send_packet(random_header(), 14'd21);
   endtask

   task automatic test_extreme_words();
      word_fill.push_back(32'h8000_0000);
      word_fill.push_back(32'hFFFF_FFFF);
      word_fill.push_back(32'h7FFF_FFFF);
      word_fill.push_back(32'h0000_0000);
      word_fill.push_back(32'h8000_0001);
      word_fill.push_back(32'h0000_0001);
      send_packet(random_header(), 14'd40);
   endtask

   task automatic test_long_packet();
      send_packet({16{8'hFF}}, 14'd300);
   endtask

   task automatic test_random_packets();
      int unsigned start_bytes;
      int unsigned pkts;
      length_type len;
      start_bytes = bytes_sent;
      pkts = 0;
      while (bytes_sent - start_bytes < RANDOM_BYTES || pkts < RANDOM_PKTS) begin
         case ($urandom_range(0, 19))
            0, 1, 2:   len = length_type'($urandom_range(0, 16));
            3, 4, 5:   len = length_type'($urandom_range(17, 20));
            17, 18:    len = length_type'($urandom_range(65, 200));
            19:        len = length_type'($urandom_range(201, 600));
            default:   len = length_type'($urandom_range(21, 64));
         endcase
         send_packet(random_header(), len);
         pkts++;
      end
   endtask

   // Check each accepted result against the oldest expectation.
   always @(posedge clock) begin
      checksum_result_type want;
      logic next_ready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (checksum_queue.size() == 0) begin
            $error("unexpected result: checksum_value %0d, length_field %0d",
                   rsp_tdata[22:0], rsp_tdata[36:23]);
            error_count++;
         end else begin
            want = checksum_queue.pop_front();
            if (rsp_tdata[22:0] !== want.checksum) begin
               $error("checksum_value: expected %0d, actual %0d",
                      want.checksum, rsp_tdata[22:0]);
               error_count++;
            end
            if (rsp_tdata[36:23] !== want.length) begin
               $error("length_field: expected %0d, actual %0d",
                      want.length, rsp_tdata[36:23]);
               error_count++;
            end
         end
      end
      case (cycle_count[9:8])
         2'd0: next_ready = 1'b1;
         2'd1: next_ready = 1'($urandom_range(0, 1));
         2'd2: next_ready = (cycle_count[1:0] == 2'd0);
         default: begin
            if (hold_left != 0) begin
               hold_left--;
               next_ready = 1'b0;
            end else begin
               next_ready = 1'b1;
               if ($urandom_range(0, 7) == 0) hold_left = $urandom_range(1, 24);
            end
         end
      endcase
      rsp_tready <= next_ready;
   end

   initial begin
      clear_packet_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_short_length();
      test_partial_word();
      test_extreme_words();
      test_long_packet();
      test_random_packets();
      req_tvalid <= 1'b0;
      while (checksum_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

/* packet_header_payload_checksum.f */
src/phpc_pkg.sv
src/packet_header_payload_checksum.sv
verif/tb_top.sv
